FILE: design/nge_pkg.sv
// Shared types, constants and gain root table of the noise gate / expander.
package nge_pkg;

  localparam int LANES    = 4;
  localparam int CHANNELS = 4;
  localparam int SMP_W    = 24;

  localparam logic signed [15:0] SILENCE_Q8    = -16'sd30720;
  localparam logic signed [15:0] RANGE_RESET   = -16'sd20480;
  localparam logic signed [15:0] THRESH_RESET  = -16'sd15360;
  localparam logic [18:0]        DB_PER_LOG2   = 19'd394566;
  localparam logic [21:0]        LOG2_PER_DB   = 22'd2786635;
  localparam logic [30:0]        GAIN_ONE      = 31'h4000_0000;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_HYST      = 3'd2;
  localparam logic [2:0] REG_RATIO     = 3'd3;
  localparam logic [2:0] REG_RANGE     = 3'd4;
  localparam logic [2:0] REG_ATTACK    = 3'd5;
  localparam logic [2:0] REG_RELEASE   = 3'd6;
  localparam logic [2:0] REG_HOLD      = 3'd7;

  typedef enum logic [1:0] {
    MODE_BYPASS,
    MODE_GATE,
    MODE_EXPAND,
    MODE_RESERVED
  } mode_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PEAK, ST_LSQ, ST_LNRM, ST_LDB, ST_LDB2, ST_DECIDE,
    ST_EXP, ST_EXP2, ST_SMUL, ST_SACC, ST_GP, ST_GP2, ST_GSQ, ST_GRND,
    ST_GSH, ST_OMUL, ST_ORND, ST_DONE
  } state_t;

  typedef logic [15:0][30:0] root_tbl_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bt;
    v  = v_in;
    r  = '0;
    bt = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // 2^30 * 2^-(2^-(k+1)), k = 0..15, by repeated floor square roots
  function automatic root_tbl_t make_roots();
    root_tbl_t   t;
    logic [63:0] rt;
    rt = isqrt64(64'h1 << 59);
    for (int k = 0; k < 16; k++) begin
      t[k] = rt[30:0];
      rt   = isqrt64(rt << 30);
    end
    return t;
  endfunction

  localparam root_tbl_t ROOTS = make_roots();

endpackage

FILE: design/nge_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
module nge_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);
  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end
endmodule

FILE: design/noise_gate_expander.sv
// Noise gate / downward expander top level.
// One frame of four 24-bit channels is taken per transaction; the block then
// drops ready and works the frame through one shared 32x32 multiplier under a
// small sequencer: 16 squaring rounds for the log2 of the peak, one scaling
// multiply to dB, one for the expander target, one for the one-pole smoother,
// one dB-to-log2 multiply, 16 root multiplies that build the linear gain, and
// one multiply per channel. Each multiply is issued, then its registered
// product is used. A silent frame skips the log2 rounds, a bypassed frame
// goes straight to the result, and the expander target multiply runs only
// for a closed gate in expander mode. The result sits in an output register,
// so the next frame is accepted while it waits; the sequencer stalls at the
// end only if the previous result is still not taken. Writing range_db also
// loads the smoothed attenuation with the clamped range. Configuration is
// written through cfg_we / cfg_index / cfg_data; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module noise_gate_expander (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sample_0 [23:0], sample_1 [47:24], sample_2 [71:48], sample_3 [95:72]
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_sample_0..3 [95:0] (24 bits each), attenuation_db [111:96]
  output logic [111:0] m_axis_tdata,
  // gate_open [0]
  output logic [0:0]   m_axis_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [19:0]  cfg_data
);
  import nge_pkg::*;

  // configuration
  mode_t              mode;
  logic signed [15:0] threshold_db;
  logic [13:0]        hysteresis_db;
  logic [14:0]        ratio;
  logic signed [15:0] range_db;
  logic [15:0]        attack_coeff;
  logic [15:0]        release_coeff;
  logic [19:0]        hold_samples;

  // gate state
  logic               open_flag;
  logic [19:0]        hold_left;
  logic signed [15:0] smoothed_atten;

  state_t state, state_next;

  // frame datapath
  logic signed [SMP_W-1:0] x   [LANES];
  logic signed [SMP_W-1:0] res [LANES];
  logic [30:0]        lx;
  logic [15:0]        frac;
  logic [4:0]         e_q;
  logic [3:0]         cnt;
  logic signed [15:0] lvl;
  logic signed [15:0] target;
  logic [15:0]        below;
  logic               dneg;
  logic [20:0]        p;
  logic [30:0]        g;
  logic [1:0]         lane;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  nge_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  // ---------------------------------------------------------------- helpers
  logic               bypass;
  logic signed [15:0] rng;
  logic [15:0]        rng_mag;
  logic [23:0]        absx [LANES];
  logic [23:0]        peak;
  logic [4:0]         msb;
  logic [30:0]        lx_init;
  logic [20:0]        neg_log;

  assign bypass = !(mode == MODE_GATE || mode == MODE_EXPAND);
  assign rng    = (range_db > 16'sd0) ? 16'sd0 :
                  (range_db < SILENCE_Q8) ? SILENCE_Q8 : range_db;
  assign rng_mag = 16'(-17'(rng));

  always_comb begin
    peak = '0;
    for (int i = 0; i < LANES; i++) begin
      absx[i] = x[i][SMP_W-1] ? 24'(~x[i] + 24'd1) : 24'(x[i]);
      if (absx[i] > peak) peak = absx[i];
    end
    msb = '0;
    for (int i = 0; i < SMP_W; i++) begin
      if (peak[i]) msb = 5'(i);
    end
  end

  assign lx_init = 31'(peak) << (5'd30 - msb);
  assign neg_log = {5'(5'd23 - e_q), 16'b0} - {5'b0, frac};

  // --------------------------------------------------------- decide helpers
  logic signed [17:0] upper, lower, lvl_x;
  logic               open_n;
  logic [19:0]        hold_n;
  logic signed [17:0] below_s;

  assign upper   = 18'(threshold_db) + 18'(signed'({1'b0, hysteresis_db}));
  assign lower   = 18'(threshold_db) - 18'(signed'({1'b0, hysteresis_db}));
  assign lvl_x   = 18'(lvl);
  assign below_s = 18'(threshold_db) - lvl_x;

  always_comb begin
    open_n = open_flag;
    hold_n = hold_left;
    if (lvl_x >= upper) begin
      open_n = 1'b1;
      hold_n = hold_samples;
    end else if (open_flag) begin
      if (lvl_x > lower) hold_n = hold_samples;
      else if (hold_left != '0) hold_n = hold_left - 20'd1;
      else open_n = 1'b0;
    end
  end

  // ------------------------------------------------------ arithmetic helpers
  logic [14:0]        ratio_eff;
  logic [23:0]        att_mag;
  logic [15:0]        coeff;
  logic signed [16:0] diff;
  logic [16:0]        diff_mag;
  logic signed [35:0] acc;
  logic [35:0]        acc_mag;
  logic signed [20:0] sm_new;
  logic signed [15:0] sm_clamped;
  logic [15:0]        d_mag;
  logic [15:0]        pf;
  logic [31:0]        g_sh;
  logic [4:0]         ip;
  logic [24:0]        y;
  logic signed [SMP_W-1:0] y_out;
  logic [16:0]        db_mag;

  assign ratio_eff = (ratio < 15'd256) ? 15'd256 : ratio;
  assign att_mag   = 24'((prod + 64'd128) >> 8);
  assign coeff     = (target > smoothed_atten) ? attack_coeff : release_coeff;
  assign diff      = 17'(smoothed_atten) - 17'(target);
  assign diff_mag  = diff[16] ? 17'(-diff) : 17'(diff);
  assign acc = {{4{target[15]}}, target, 16'b0} +
               (dneg ? -signed'({4'b0, prod[31:0]}) : signed'({4'b0, prod[31:0]}));
  assign acc_mag = acc[35] ? 36'(-acc) : 36'(acc);
  assign sm_new  = (acc <= 36'sd0) ? -21'(signed'({1'b0, 20'((acc_mag + 36'd32768) >> 16)}))
                                   : 21'(signed'({1'b0, 20'((acc_mag + 36'd32768) >> 16)}));
  assign sm_clamped = (sm_new > 21'sd0) ? 16'sd0 :
                      (sm_new < 21'(SILENCE_Q8)) ? SILENCE_Q8 : sm_new[15:0];
  assign d_mag   = smoothed_atten[15] ? 16'(-smoothed_atten) : 16'd0;
  assign pf      = p[15:0];
  assign ip      = p[20:16];
  assign g_sh    = (ip == 5'd0) ? 32'(g) :
                   (32'(g) + (32'd1 << (ip - 5'd1))) >> ip;
  assign y       = 25'((prod + 64'h2000_0000) >> 30);
  assign db_mag  = 17'((prod + 64'h80_0000) >> 24);

  always_comb begin
    if (x[lane][SMP_W-1]) begin
      y_out = (y > 25'h80_0000) ? -24'sd8388608 : 24'(-y);
    end else begin
      y_out = (y > 25'h7F_FFFF) ? 24'sd8388607 : 24'(y);
    end
  end

  // ------------------------------------------------------- multiplier select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_LSQ:  begin mul_a = 32'(lx);       mul_b = 32'(lx);          end
      ST_LDB:  begin mul_a = 32'(neg_log);  mul_b = 32'(DB_PER_LOG2); end
      ST_EXP:  begin mul_a = 32'(below);    mul_b = 32'(ratio_eff - 15'd256); end
      ST_SMUL: begin mul_a = 32'(coeff);    mul_b = 32'(diff_mag);    end
      ST_GP:   begin mul_a = 32'(d_mag);    mul_b = 32'(LOG2_PER_DB); end
      ST_GSQ:  begin
        mul_a = 32'(g);
        mul_b = pf[4'd15 - cnt] ? 32'(ROOTS[cnt]) : 32'(GAIN_ONE);
      end
      ST_OMUL: begin mul_a = 32'(absx[lane]); mul_b = 32'(g);        end
      default: begin mul_a = '0;            mul_b = '0;               end
    endcase
  end

  // ---------------------------------------------------------- state machine
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_axis_tvalid) state_next = ST_PEAK;
      ST_PEAK: begin
        if (bypass)              state_next = ST_DONE;
        else if (peak == '0)     state_next = ST_DECIDE;
        else                     state_next = ST_LSQ;
      end
      ST_LSQ:    state_next = ST_LNRM;
      ST_LNRM:   state_next = (cnt == 4'd15) ? ST_LDB : ST_LSQ;
      ST_LDB:    state_next = ST_LDB2;
      ST_LDB2:   state_next = ST_DECIDE;
      ST_DECIDE: state_next = (open_n || mode == MODE_GATE) ? ST_SMUL : ST_EXP;
      ST_EXP:    state_next = ST_EXP2;
      ST_EXP2:   state_next = ST_SMUL;
      ST_SMUL:   state_next = ST_SACC;
      ST_SACC:   state_next = ST_GP;
      ST_GP:     state_next = ST_GP2;
      ST_GP2:    state_next = ST_GSQ;
      ST_GSQ:    state_next = ST_GRND;
      ST_GRND:   state_next = (cnt == 4'd15) ? ST_GSH : ST_GSQ;
      ST_GSH:    state_next = ST_OMUL;
      ST_OMUL:   state_next = ST_ORND;
      ST_ORND:   state_next = (lane == 2'(LANES - 1)) ? ST_DONE : ST_OMUL;
      ST_DONE:   if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // ------------------------------------------------- configuration and state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_BYPASS;
      threshold_db   <= THRESH_RESET;
      hysteresis_db  <= '0;
      ratio          <= 15'd512;
      range_db       <= RANGE_RESET;
      attack_coeff   <= '0;
      release_coeff  <= '0;
      hold_samples   <= '0;
      open_flag      <= 1'b0;
      hold_left      <= '0;
      smoothed_atten <= RANGE_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:      mode          <= mode_t'(cfg_data[1:0]);
          REG_THRESHOLD: threshold_db  <= signed'(cfg_data[15:0]);
          REG_HYST:      hysteresis_db <= cfg_data[13:0];
          REG_RATIO:     ratio         <= cfg_data[14:0];
          REG_RANGE: begin
            range_db       <= signed'(cfg_data[15:0]);
            // load the smoother with the clamped range
            smoothed_atten <= (signed'(cfg_data[15:0]) > 16'sd0) ? 16'sd0 :
                              (signed'(cfg_data[15:0]) < SILENCE_Q8) ? SILENCE_Q8 :
                              signed'(cfg_data[15:0]);
          end
          REG_ATTACK:    attack_coeff  <= cfg_data[15:0];
          REG_RELEASE:   release_coeff <= cfg_data[15:0];
          REG_HOLD:      hold_samples  <= cfg_data;
        endcase
      end
      if (state == ST_DECIDE) begin
        open_flag <= open_n;
        hold_left <= hold_n;
      end
      if (state == ST_SACC) smoothed_atten <= sm_clamped;
    end
  end

  // ------------------------------------------------------------ datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        // capture the frame; lanes past CHANNELS read as silence
        for (int i = 0; i < LANES; i++) begin
          x[i] <= (i < CHANNELS) ? signed'(s_axis_tdata[i*SMP_W +: SMP_W]) : '0;
        end
      end
      ST_PEAK: begin
        lx   <= lx_init;
        e_q  <= msb;
        frac <= '0;
        cnt  <= '0;
        lvl  <= SILENCE_Q8;
        for (int i = 0; i < LANES; i++) res[i] <= x[i];
      end
      ST_LNRM: begin
        // square result in Q30; a carry into bit 31 is the next fraction bit
        frac <= {frac[14:0], prod[61]};
        lx   <= prod[61] ? prod[61:31] : prod[60:30];
        cnt  <= cnt + 4'd1;
      end
      ST_LDB2: lvl <= (db_mag > 17'd30720) ? SILENCE_Q8 : 16'(-db_mag);
      ST_DECIDE: begin
        below <= below_s[17] ? 16'd0 : below_s[15:0];
        if (open_n) target <= 16'sd0;
        else        target <= rng;
      end
      ST_EXP2: target <= (att_mag > 24'(rng_mag)) ? rng : 16'(-att_mag);
      ST_SMUL: dneg <= diff[16];
      ST_GP2: begin
        p   <= 21'((prod + 64'd32768) >> 16);
        g   <= GAIN_ONE;
        cnt <= '0;
      end
      ST_GRND: begin
        g   <= 31'((prod + 64'h2000_0000) >> 30);
        cnt <= cnt + 4'd1;
      end
      ST_GSH: begin
        g    <= g_sh[30:0];
        lane <= '0;
      end
      ST_ORND: begin
        res[lane] <= y_out;
        lane      <= lane + 2'd1;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      for (int i = 0; i < LANES; i++) m_axis_tdata[i*SMP_W +: SMP_W] <= res[i];
      m_axis_tdata[111:96] <= smoothed_atten;
      m_axis_tuser[0]      <= open_flag;
    end
  end

  // ------------------------------------------------------------ assertions
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state == ST_PEAK)
    else $error("accepted frame did not start processing");

  a_atten_range: assert property (@(posedge clk) disable iff (rst)
    smoothed_atten <= 16'sd0 && smoothed_atten >= SILENCE_Q8)
    else $error("smoothed attenuation out of range");

  a_bypass_state: assert property (@(posedge clk) disable iff (rst)
    state == ST_PEAK && bypass |=> $stable(open_flag) && $stable(hold_left))
    else $error("bypass frame changed gate state");

  a_hold_only_decide: assert property (@(posedge clk) disable iff (rst)
    state != ST_DECIDE |=> $stable(hold_left))
    else $error("hold counter moved outside decision step");

endmodule

FILE: tb/noise_gate_expander_test.sv
// Self-checking testbench of the noise gate / expander: directed table, random frames.
module noise_gate_expander_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nge_pkg::*;

  typedef struct {
    logic signed [23:0] smp [4];
    logic               open;
    logic signed [15:0] atten;
  } frame_res_t;

  // One row of the directed table: a frame and, where known, its result.
  typedef struct {
    logic signed [23:0] smp [4];
    bit                 known;
    frame_res_t         res;
  } stim_row_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;   // sample_0..3, 24 bits each from the lowest bit up
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;   // out_sample_0..3, then attenuation_db
  logic [0:0]   m_axis_tuser;   // gate_open
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [19:0]  cfg_data;

  noise_gate_expander uut (.*);

  // Predictor copy of the registers and the gate state.
  mode_t              cur_mode;
  logic signed [15:0] cur_thresh;
  logic [13:0]        cur_hyst;
  logic [14:0]        cur_ratio;
  logic signed [15:0] cur_range;
  logic [15:0]        cur_attack;
  logic [15:0]        cur_release;
  logic [19:0]        cur_hold;
  bit                 gate_is_open;
  logic [19:0]        hold_count;
  int                 smooth_db;

  frame_res_t expected_frames [$];
  int  fail_count;
  int  frames_checked;
  bit  quiet_mode;       // no random idling on either side
  bit  known_pending;
  frame_res_t known_res;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL noise_gate_expander");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v_in);
    longint unsigned v, r, b;
    v = v_in;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int clamp_db(longint r);
    if (r > 0) return 0;
    if (r < -30720) return -30720;
    return int'(r);
  endfunction

  // Peak magnitude to dB Q8 through log2 by repeated squaring.
  function automatic int peak_to_db(longint unsigned m_in);
    longint unsigned m, x, frac, neg;
    int e;
    longint dbv;
    m = m_in;
    e = 0;
    frac = 0;
    if (m == 0) return -30720;
    if (m > 64'h800000) m = 64'h800000;
    while ((m >> (e + 1)) != 0) e++;
    x = m << (30 - e);
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      frac <<= 1;
      if (x >= (64'd1 << 31)) begin
        frac |= 1;
        x >>= 1;
      end
    end
    neg = longint'(23 - e) * 65536 - frac;
    dbv = -longint'((neg * 394566 + (64'd1 << 23)) >> 24);
    return clamp_db(dbv);
  endfunction

  function automatic longint unsigned db_to_gain(int s);
    longint unsigned d, p, ip, g, rt;
    d = (s < 0) ? longint'(-s) : 0;
    p = (d * 2786635 + 32768) >> 16;
    ip = p >> 16;
    g = 64'd1 << 30;
    rt = int_sqrt(64'd1 << 59);
    for (int k = 0; k < 16; k++) begin
      if ((p >> (15 - k)) & 1) g = (g * rt + (64'd1 << 29)) >> 30;
      rt = int_sqrt(rt << 30);
    end
    if (ip >= 40) return 0;
    if (ip > 0) g = (g + (64'd1 << (ip - 1))) >> ip;
    return g;
  endfunction

  // Advance the gate state by one frame and return its result.
  function automatic frame_res_t gate_frame(logic signed [23:0] smp [4]);
    frame_res_t r;
    longint unsigned peak, a, g;
    longint y, acc, below, att, rr;
    int lvl, upper, lower, target, rng;
    logic [15:0] c;
    peak = 0;
    rng = clamp_db(cur_range);
    for (int i = 0; i < 4; i++) begin
      a = (smp[i] < 0) ? longint'(-longint'(smp[i])) : longint'(smp[i]);
      if (a > peak) peak = a;
      r.smp[i] = smp[i];
    end
    if (cur_mode == MODE_GATE || cur_mode == MODE_EXPAND) begin
      lvl = peak_to_db(peak);
      upper = int'(cur_thresh) + int'(cur_hyst);
      lower = int'(cur_thresh) - int'(cur_hyst);
      if (lvl >= upper) begin
        gate_is_open = 1;
        hold_count = cur_hold;
      end else if (gate_is_open) begin
        if (lvl > lower) hold_count = cur_hold;
        else if (hold_count > 0) hold_count--;
        else gate_is_open = 0;
      end
      if (gate_is_open) target = 0;
      else if (cur_mode == MODE_GATE) target = rng;
      else begin
        below = longint'(cur_thresh) - lvl;
        rr = (cur_ratio < 256) ? 256 : longint'(cur_ratio);
        if (below < 0) below = 0;
        att = -((below * (rr - 256) + 128) >>> 8);
        target = (att < rng) ? rng : int'(att);
      end
      c = (target > smooth_db) ? cur_attack : cur_release;
      acc = longint'(c) * smooth_db + longint'(65536 - int'(c)) * target;
      if (acc <= 0) smooth_db = -int'((-acc + 32768) >>> 16);
      else smooth_db = int'((acc + 32768) >>> 16);
      smooth_db = clamp_db(smooth_db);
      g = db_to_gain(smooth_db);
      for (int i = 0; i < 4; i++) begin
        a = (smp[i] < 0) ? longint'(-longint'(smp[i])) : longint'(smp[i]);
        y = longint'((a * g + (64'd1 << 29)) >> 30);
        if (smp[i] < 0) y = -y;
        if (y > 8388607) y = 8388607;
        if (y < -8388608) y = -8388608;
        r.smp[i] = y[23:0];
      end
    end
    r.open = gate_is_open;
    r.atten = smooth_db[15:0];
    return r;
  endfunction

  // Write one register, held idle; mirror it in the predictor.
  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_MODE:      cur_mode = mode_t'(val[1:0]);
      REG_THRESHOLD: cur_thresh = val[15:0];
      REG_HYST:      cur_hyst = val[13:0];
      REG_RATIO:     cur_ratio = val[14:0];
      REG_RANGE: begin
        cur_range = val[15:0];
        smooth_db = clamp_db(cur_range);
      end
      REG_ATTACK:    cur_attack = val[15:0];
      REG_RELEASE:   cur_release = val[15:0];
      REG_HOLD:      cur_hold = val;
      default: ;
    endcase
  endtask

  // Hold until every expected frame has come back, then let the block settle.
  task automatic drain_results();
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send_frame(logic signed [23:0] smp [4], bit known, frame_res_t kres);
    frame_res_t p;
    // step past the edge that dropped valid for the previous transaction
    @(posedge clk);
    if (!quiet_mode) begin
      while ($urandom_range(99) < 30) @(posedge clk);
    end
    p = gate_frame(smp);
    if (known) p = kres;
    expected_frames.push_back(p);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {smp[3], smp[2], smp[1], smp[0]};
    do @(posedge clk); while (!s_axis_tready);
    s_axis_tvalid <= 0;
  endtask

  // Receiver side: random stalls, compare each result with the oldest one due.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, m_axis_tdata);
          fail_count++;
        end else begin
          frame_res_t e;
          e = expected_frames.pop_front();
          frames_checked++;
          for (int i = 0; i < 4; i++) begin
            if (m_axis_tdata[24*i +: 24] !== e.smp[i]) begin
              $display("%0t: out_sample_%0d expected %0d actual %0d", $time, i,
                       e.smp[i], $signed(m_axis_tdata[24*i +: 24]));
              fail_count++;
            end
          end
          if (m_axis_tuser[0] !== e.open) begin
            $display("%0t: gate_open expected %0d actual %0d", $time, e.open,
                     m_axis_tuser[0]);
            fail_count++;
          end
          if (m_axis_tdata[111:96] !== e.atten) begin
            $display("%0t: attenuation_db expected %0d actual %0d", $time, e.atten,
                     $signed(m_axis_tdata[111:96]));
            fail_count++;
          end
        end
      end
      m_axis_tready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 30);
    end
  end

  task automatic random_regs();
    write_reg(REG_MODE, 20'($urandom_range(3)));
    write_reg(REG_THRESHOLD, 20'(-$signed(17'($urandom_range(30720)))));
    write_reg(REG_HYST, $urandom_range(3) == 0 ? 20'($urandom_range(16383))
                                               : 20'($urandom_range(1536)));
    write_reg(REG_RATIO, $urandom_range(4) == 0 ? 20'($urandom_range(32767))
                                                : 20'($urandom_range(256, 2048)));
    write_reg(REG_RANGE, $urandom_range(7) == 0 ? 20'($urandom_range(65535))
                                                : 20'(-$signed(17'($urandom_range(30720)))));
    write_reg(REG_ATTACK, $urandom_range(3) == 0 ? 20'($urandom_range(65535))
                                                 : 20'($urandom_range(65535, 40000)));
    write_reg(REG_RELEASE, $urandom_range(3) == 0 ? 20'($urandom_range(65535))
                                                  : 20'($urandom_range(65535, 50000)));
    write_reg(REG_HOLD, $urandom_range(5) == 0 ? 20'($urandom)
                                               : 20'($urandom_range(20)));
  endtask

  function automatic logic signed [23:0] rand_sample(int loud);
    case ($urandom_range(7))
      0: return 24'sh800000;
      1: return 24'sh7FFFFF;
      2: return 24'sd0;
      3: return 24'($urandom);
      default: return 24'($signed(25'($urandom_range(loud))) *
                          ($urandom_range(1) ? 1 : -1));
    endcase
  endfunction

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    frame_res_t none;
    logic signed [23:0] smp [4];
    int loud;

    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_we = 0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    fail_count = 0;
    frames_checked = 0;
    quiet_mode = 0;
    cur_mode = MODE_BYPASS;
    cur_thresh = THRESH_RESET;
    cur_hyst = 0;
    cur_ratio = 512;
    cur_range = RANGE_RESET;
    cur_attack = 0;
    cur_release = 0;
    cur_hold = 0;
    gate_is_open = 0;
    hold_count = 0;
    smooth_db = RANGE_RESET;
    none = '{smp: '{0, 0, 0, 0}, open: 0, atten: 0};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Bypass after reset: samples pass, closed gate, reset range reported.
    row.known = 1;
    row.smp = '{24'sh7FFFFF, 24'sh800000, 24'sd1, -24'sd1};
    row.res = '{smp: row.smp, open: 0, atten: RANGE_RESET};
    rows.push_back(row);
    row.smp = '{0, 0, 0, 0};
    row.res = '{smp: row.smp, open: 0, atten: RANGE_RESET};
    rows.push_back(row);
    foreach (rows[i]) send_frame(rows[i].smp, rows[i].known, rows[i].res);
    drain_results();

    // Hard gate with instant smoothing: closed gives range, full scale opens.
    write_reg(REG_MODE, 20'(MODE_GATE));
    write_reg(REG_HOLD, 20'd2);
    rows.delete();
    row.known = 1;
    row.smp = '{0, 0, 0, 0};
    row.res = '{smp: '{0, 0, 0, 0}, open: 0, atten: RANGE_RESET};
    rows.push_back(row);
    row.smp = '{24'sh7FFFFF, 24'sh800000, 0, 0};
    row.res = '{smp: row.smp, open: 1, atten: 0};
    rows.push_back(row);
    row.known = 0;
    // Hold countdown, then close; peak of the most negative sample, silence.
    for (int i = 0; i < 5; i++) begin
      row.smp = '{24'sd3, -24'sd5, 24'sd0, 24'sd2};
      rows.push_back(row);
    end
    row.smp = '{24'sh800000, 0, 0, 0};
    rows.push_back(row);
    foreach (rows[i]) send_frame(rows[i].smp, rows[i].known, rows[i].res);
    drain_results();

    // Expander, ratio below one, reserved mode, positive and deepest range.
    write_reg(REG_MODE, 20'(MODE_EXPAND));
    write_reg(REG_RATIO, 20'd0);
    write_reg(REG_HYST, 20'd12800);
    write_reg(REG_THRESHOLD, 20'(-16'sd30720));
    write_reg(REG_ATTACK, 20'd65535);
    write_reg(REG_RELEASE, 20'd65535);
    write_reg(REG_RANGE, 20'h07FFF);
    rows.delete();
    row.known = 0;
    row.smp = '{24'sd100, 0, 0, 0};
    rows.push_back(row);
    row.smp = '{-24'sd4000, 24'sd7, 0, 0};
    rows.push_back(row);
    foreach (rows[i]) send_frame(rows[i].smp, 0, none);
    drain_results();
    write_reg(REG_RATIO, 20'd25600);
    write_reg(REG_THRESHOLD, 20'd0);
    write_reg(REG_HYST, 20'd0);
    write_reg(REG_RELEASE, 20'd0);
    write_reg(REG_RANGE, 20'h08000);
    write_reg(REG_HOLD, 20'hFFFFF);
    foreach (rows[i]) send_frame(rows[i].smp, 0, none);
    drain_results();
    write_reg(REG_MODE, 20'(MODE_RESERVED));
    send_frame(rows[0].smp, 0, none);
    drain_results();

    // Random phases; the first one runs with no idling at all.
    for (int ph = 0; ph < 22; ph++) begin
      quiet_mode = (ph == 0);
      random_regs();
      loud = (ph % 3 == 0) ? 8388607 : ((ph % 3 == 1) ? 65535 : 2047);
      for (int n = 0; n < 50; n++) begin
        for (int i = 0; i < 4; i++) smp[i] = rand_sample(loud);
        send_frame(smp, 0, none);
      end
      // Drain fully before the next register set.
      drain_results();
    end
    quiet_mode = 0;

    repeat (100) @(posedge clk);
    $display("Checked %0d frames over bypass, gate, expander and reserved modes,", frames_checked);
    $display("with hold countdowns, hysteresis and register extremes.");
    if (fail_count == 0 && expected_frames.size() == 0) begin
      $display("PASS noise_gate_expander");
    end else begin
      $display("FAIL noise_gate_expander");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/nge_pkg.sv
design/nge_mul.sv
design/noise_gate_expander.sv
tb/noise_gate_expander_test.sv
